### hw/rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared sizes, codes, controller types and data helpers for the
// positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int CAPACITY   = 128;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = ((LEN_W > 8) ? LEN_W : 8) + 1;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_LOCATE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FINISH,
    S_OUT
  } pls_state_t;

  typedef struct packed {
    logic load;
    logic walk_start;
    logic walk_en;
    logic finish;
  } pls_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_done;
  } pls_stat_t;

  function automatic logic [DATA_WIDTH-1:0] to_store(input logic [31:0] v);
    logic [63:0] t;
    t = {32'b0, v};
    return t[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] t;
    t = 64'(signed'(d));
    return t[31:0];
  endfunction

endpackage

### hw/rtl/pls_in_if.sv
// ----------------------------------------------------------------------------
// pls_in_if
// Request channel: opcode, position and value with valid/ready.
// ----------------------------------------------------------------------------
interface pls_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  position;
  logic [31:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

### hw/rtl/pls_out_if.sv
// ----------------------------------------------------------------------------
// pls_out_if
// Result channel: status, fetched value, match position, length, empty flag.
// ----------------------------------------------------------------------------
interface pls_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_value;
  logic [7:0]  found_position;
  logic [7:0]  count_now;
  logic        is_empty;

  modport source (output valid, status, read_value, found_position, count_now, is_empty,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, count_now, is_empty,
                  output ready);
endinterface

### hw/rtl/pls_ram.sv
// ----------------------------------------------------------------------------
// pls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/pls_datapath.sv
// ----------------------------------------------------------------------------
// pls_datapath
// Request registers, length count, element RAM, shift/scan walker and
// result registers.
// ----------------------------------------------------------------------------
module pls_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pls_pkg::pls_cmd_t           cmd,
  output pls_pkg::pls_stat_t          stat,
  input  logic [2:0]                  in_opcode,
  input  logic [7:0]                  in_position,
  input  logic [31:0]                 in_value,
  output logic [1:0]                  out_status,
  output logic [31:0]                 out_read_value,
  output logic [7:0]                  out_found_position,
  output logic [7:0]                  out_count_now,
  output logic                        out_is_empty
);
  import pls_pkg::*;

  logic [2:0]            op_r, op_nxt;
  logic [7:0]            pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [ADDR_W-1:0]     ptr_r, ptr_nxt;
  logic [LEN_W-1:0]      cnt_r, cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic [ADDR_W-1:0]     paddr_r, paddr_nxt;
  logic                  hit_r, hit_nxt;
  logic [31:0]           rdv_r, rdv_nxt;
  logic [7:0]            found_r, found_nxt;
  logic [1:0]            ostat_r, ostat_nxt;
  logic [31:0]           ordv_r, ordv_nxt;
  logic [7:0]            ofound_r, ofound_nxt;
  logic [7:0]            ocnt_r, ocnt_nxt;
  logic                  oempty_r, oempty_nxt;

  logic [CMP_W-1:0]      pos_x, len_x;
  logic [ADDR_W-1:0]     pos_m1;
  logic [1:0]            status;
  logic                  issue;
  logic [LEN_W-1:0]      paddr_p1;

  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  assign pos_x    = CMP_W'(pos_r);
  assign len_x    = CMP_W'(len_r);
  assign pos_m1   = ADDR_W'(pos_x - CMP_W'(1));
  assign paddr_p1 = LEN_W'(paddr_r) + LEN_W'(1);

  always_comb begin
    case (op_r)
      OP_INSERT: begin
        if (len_r == LEN_W'(CAPACITY)) begin
          status = ST_FULL;
        end else if (pos_x == '0 || pos_x > len_x + CMP_W'(1)) begin
          status = ST_RANGE;
        end else begin
          status = ST_OK;
        end
      end
      OP_DELETE, OP_GET: begin
        status = (pos_x == '0 || pos_x > len_x) ? ST_RANGE : ST_OK;
      end
      default: status = ST_OK;
    endcase
  end

  assign stat.need_walk = (status == ST_OK) &&
                          (op_r == OP_INSERT || op_r == OP_DELETE ||
                           op_r == OP_GET || op_r == OP_LOCATE);
  assign stat.walk_done = (cnt_r == '0) && !pend_r;

  assign issue = cmd.walk_en && (cnt_r != '0);

  always_comb begin
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    len_nxt    = len_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = 1'b0;
    paddr_nxt  = paddr_r;
    hit_nxt    = hit_r;
    rdv_nxt    = rdv_r;
    found_nxt  = found_r;
    ostat_nxt  = ostat_r;
    ordv_nxt   = ordv_r;
    ofound_nxt = ofound_r;
    ocnt_nxt   = ocnt_r;
    oempty_nxt = oempty_r;
    ram_we     = 1'b0;
    ram_waddr  = pos_m1;
    ram_wdata  = val_r;

    if (cmd.load) begin
      op_nxt    = in_opcode;
      pos_nxt   = in_position;
      val_nxt   = to_store(in_value);
      cnt_nxt   = '0;
      hit_nxt   = 1'b0;
      rdv_nxt   = '0;
      found_nxt = '0;
    end

    if (cmd.walk_start) begin
      unique case (op_r)
        OP_INSERT: begin
          ptr_nxt = ADDR_W'(len_x - CMP_W'(1));
          cnt_nxt = LEN_W'(len_x + CMP_W'(1) - pos_x);
        end
        OP_DELETE: begin
          ptr_nxt = pos_m1;
          cnt_nxt = LEN_W'(len_x + CMP_W'(1) - pos_x);
        end
        OP_GET: begin
          ptr_nxt = pos_m1;
          cnt_nxt = LEN_W'(1);
        end
        default: begin
          ptr_nxt = '0;
          cnt_nxt = len_r;
        end
      endcase
    end

    if (issue) begin
      pend_nxt  = 1'b1;
      paddr_nxt = ptr_r;
      cnt_nxt   = cnt_r - LEN_W'(1);
      ptr_nxt   = (op_r == OP_INSERT) ? ptr_r - ADDR_W'(1) : ptr_r + ADDR_W'(1);
    end

    if (cmd.walk_en && pend_r) begin
      case (op_r)
        OP_INSERT: begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(paddr_p1);
          ram_wdata = ram_rdata;
        end
        OP_DELETE: begin
          if (paddr_r == pos_m1) begin
            rdv_nxt = to_out(ram_rdata);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = paddr_r - ADDR_W'(1);
            ram_wdata = ram_rdata;
          end
        end
        OP_GET: rdv_nxt = to_out(ram_rdata);
        OP_LOCATE: begin
          if (!hit_r && ram_rdata == val_r) begin
            hit_nxt   = 1'b1;
            found_nxt = 8'(paddr_p1);
            cnt_nxt   = '0;
          end
        end
        default: ;
      endcase
    end

    if (cmd.finish) begin
      if (status == ST_OK) begin
        case (op_r)
          OP_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_m1;
            ram_wdata = val_r;
            len_nxt   = len_r + LEN_W'(1);
          end
          OP_DELETE: len_nxt = len_r - LEN_W'(1);
          OP_CLEAR:  len_nxt = '0;
          default: ;
        endcase
      end
      ostat_nxt  = status;
      ordv_nxt   = rdv_r;
      ofound_nxt = found_r;
      ocnt_nxt   = 8'(len_nxt);
      oempty_nxt = (len_nxt == '0);
    end
  end

  assign ram_re = issue;

  pls_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      hit_r  <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    ptr_r    <= ptr_nxt;
    paddr_r  <= paddr_nxt;
    rdv_r    <= rdv_nxt;
    found_r  <= found_nxt;
    ostat_r  <= ostat_nxt;
    ordv_r   <= ordv_nxt;
    ofound_r <= ofound_nxt;
    ocnt_r   <= ocnt_nxt;
    oempty_r <= oempty_nxt;
  end

  assign out_status         = ostat_r;
  assign out_read_value     = ordv_r;
  assign out_found_position = ofound_r;
  assign out_count_now      = ocnt_r;
  assign out_is_empty       = oempty_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  a_wr_gated: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (cmd.walk_en || cmd.finish))
    else $error("element write outside walk or finish");

  a_finish_idle_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (cnt_r == '0 && !pend_r))
    else $error("finish while walk still active");

  a_hit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_r && !cmd.load) |=> $stable(found_r))
    else $error("locate match overwritten");

endmodule

### hw/rtl/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl
// Request sequencer: accept, check, walk, commit, hand off result.
// ----------------------------------------------------------------------------
module pls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pls_pkg::pls_stat_t stat,
  output pls_pkg::pls_cmd_t  cmd
);
  import pls_pkg::*;

  pls_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = stat.need_walk ? S_WALK : S_FINISH;
      S_WALK:   if (stat.walk_done) state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC:   cmd.walk_start = stat.need_walk;
      S_WALK:   cmd.walk_en = 1'b1;
      S_FINISH: cmd.finish = 1'b1;
      S_OUT:    out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !stat.walk_done) |=> state_r == S_WALK)
    else $error("walk left before done");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && !in_ready))
    else $error("result dropped while stalled");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.walk_start, cmd.walk_en, cmd.finish}))
    else $error("overlapping datapath commands");

endmodule

### hw/rtl/positional_list_store_unit.sv
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Ordered list of signed values with insert, delete, get, locate and clear.
// ----------------------------------------------------------------------------
// One request at a time. Nothing is walked for clear, rejected requests and
// opcodes five to seven; a walk that covers no entry reads nothing, and
// otherwise entries are read from the element RAM: insert reads
// length-position+1 entries, delete the same, get one, locate up to one entry
// past the first match (at most length). The next request is taken only after
// the result beat, so a stall on the result side holds off the next request;
// a full list holds 128 entries.
// ----------------------------------------------------------------------------
module positional_list_store_unit (
  input  logic      clk,
  input  logic      rst_n,
  pls_in_if.sink    in_bus,
  pls_out_if.source out_bus
);
  import pls_pkg::*;

  pls_cmd_t  cmd;
  pls_stat_t stat;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pls_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_bus.opcode),
    .in_position        (in_bus.position),
    .in_value           (in_bus.value),
    .out_status         (out_bus.status),
    .out_read_value     (out_bus.read_value),
    .out_found_position (out_bus.found_position),
    .out_count_now      (out_bus.count_now),
    .out_is_empty       (out_bus.is_empty)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !in_bus.ready)
    else $error("request taken while result pending");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_list_store_unit. Requests go in over a
// valid/ready channel with random gaps, and results are taken with a randomly
// stalled ready. A scoreboard keeps its own copy of the list, predicts each
// result when a request beat is accepted, and compares every result beat
// field by field against the oldest prediction. A directed pass covers empty,
// edge and rejected cases. Random segments then grow, fill, mix and shrink
// the list, with one long result-side hold-off and one full drain.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [1:0]  status;
  logic [31:0] read_value;
  logic [7:0]  found_position;
  logic [7:0]  count_now;
  logic        is_empty;
} list_result_t;

class list_scoreboard;
  localparam int DW  = pls_pkg::DATA_WIDTH;
  localparam int CAP = pls_pkg::CAPACITY;

  logic [DW-1:0] slots [CAP];
  int            fill;
  list_result_t  due [$];
  int            errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  function int pending();
    return due.size();
  endfunction

  function logic [31:0] element_at(int idx);
    return 32'(signed'(slots[idx]));
  endfunction

  function void note_request(logic [2:0] op, logic [7:0] pos, logic [31:0] val);
    list_result_t  r;
    logic [DW-1:0] v;
    int            p;
    int            k;
    r = '0;
    v = DW'(val);
    p = int'(pos);
    case (op)
      pls_pkg::OP_INSERT: begin
        if (fill >= CAP) begin
          r.status = pls_pkg::ST_FULL;
        end else if (p < 1 || p > fill + 1) begin
          r.status = pls_pkg::ST_RANGE;
        end else begin
          for (k = fill; k >= p; k--) slots[k] = slots[k-1];
          slots[p-1] = v;
          fill++;
        end
      end
      pls_pkg::OP_DELETE: begin
        if (fill == 0 || p < 1 || p > fill) begin
          r.status = pls_pkg::ST_RANGE;
        end else begin
          r.read_value = element_at(p - 1);
          for (k = p; k < fill; k++) slots[k-1] = slots[k];
          fill--;
        end
      end
      pls_pkg::OP_GET: begin
        if (fill == 0 || p < 1 || p > fill) r.status = pls_pkg::ST_RANGE;
        else r.read_value = element_at(p - 1);
      end
      pls_pkg::OP_LOCATE: begin
        for (k = 0; k < fill; k++) begin
          if (slots[k] == v) begin
            r.found_position = 8'(k + 1);
            break;
          end
        end
      end
      pls_pkg::OP_CLEAR: fill = 0;
      default: ;
    endcase
    r.count_now = 8'(fill);
    r.is_empty  = (fill == 0);
    due.push_back(r);
  endfunction

  function void field_ok(string name, logic [31:0] e, logic [31:0] g);
    if (e !== g) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, g);
    end
  endfunction

  function void check_result(list_result_t got);
    list_result_t e;
    if (due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
      return;
    end
    e = due.pop_front();
    field_ok("status", 32'(e.status), 32'(got.status));
    field_ok("read_value", e.read_value, got.read_value);
    field_ok("found_position", 32'(e.found_position), 32'(got.found_position));
    field_ok("count_now", 32'(e.count_now), 32'(got.count_now));
    field_ok("is_empty", 32'(e.is_empty), 32'(got.is_empty));
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  localparam logic [2:0] OP_LAST        = 3'd7;
  localparam int         RANDOM_ITEMS   = 1100;
  localparam int         SEG_ITEMS      = 90;
  localparam int         HOLD_CYCLES    = 600;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         TAIL_CYCLES    = 200;

  typedef enum int {MODE_GROW, MODE_MIX, MODE_SHRINK, MODE_FILL} mix_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on = 1'b1;
  bit   hold_request = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   issued = 0;

  list_scoreboard sb = new();

  pls_in_if  in_bus ();
  pls_out_if out_bus ();

  positional_list_store_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #1 clk = ~clk;

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !(idle_on && $urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    list_result_t got;
    bit           moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_bus.valid && in_bus.ready) begin
        sb.note_request(in_bus.opcode, in_bus.position, in_bus.value);
        moved = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.status         = out_bus.status;
        got.read_value     = out_bus.read_value;
        got.found_position = out_bus.found_position;
        got.count_now      = out_bus.count_now;
        got.is_empty       = out_bus.is_empty;
        sb.check_result(got);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic [2:0] op, input logic [7:0] pos,
                           input logic [31:0] val);
    while (idle_on && $urandom_range(99) < 16) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.opcode   <= op;
    in_bus.position <= pos;
    in_bus.value    <= val;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    @(negedge clk);
    issued++;
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [2:0] pick_op(mix_mode_t m);
    int w [6];
    int r;
    int acc;
    int i;
    case (m)
      MODE_GROW:   w = '{55, 15, 13, 12, 1, 4};
      MODE_SHRINK: w = '{15, 50, 15, 14, 3, 3};
      MODE_FILL:   w = '{80, 5, 7, 6, 0, 2};
      default:     w = '{30, 25, 20, 17, 3, 5};
    endcase
    r   = $urandom_range(99);
    acc = 0;
    for (i = 0; i < 5; i++) begin
      acc += w[i];
      if (r < acc) return 3'(i);
    end
    return 3'($urandom_range(OP_LAST, OP_CLEAR + 1));
  endfunction

  function automatic logic [7:0] pick_pos(logic [2:0] op);
    int hi;
    int r;
    hi = (op == OP_INSERT) ? sb.fill + 1 : sb.fill;
    if (hi < 1) hi = 1;
    if (hi > 255) hi = 255;
    r = $urandom_range(99);
    if (r < 12) return 8'($urandom_range(255));
    if (r < 24) return ($urandom_range(1) != 0) ? 8'd1 : 8'(hi);
    return 8'($urandom_range(hi, 1));
  endfunction

  function automatic logic [31:0] pick_value(logic [2:0] op);
    logic [31:0] pool [8];
    int          r;
    pool = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h1, 32'h5555_5555, 32'haaaa_aaaa, 32'd42};
    r = $urandom_range(99);
    if (op == OP_LOCATE && sb.fill > 0 && r < 60)
      return sb.element_at($urandom_range(sb.fill - 1));
    if (r < 40) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic random_item(mix_mode_t m);
    logic [2:0] op;
    op = pick_op(m);
    send_beat(op, pick_pos(op), pick_value(op));
  endtask

  task automatic run_segment(mix_mode_t m);
    int n;
    int after_full;
    n          = 0;
    after_full = 0;
    if (m == MODE_FILL) begin
      while (after_full < 20 && n < 400) begin
        random_item(m);
        n++;
        if (sb.fill == CAPACITY) after_full++;
      end
    end else begin
      repeat (SEG_ITEMS) random_item(m);
    end
  endtask

  initial begin
    int        seg;
    mix_mode_t m;
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.opcode   = '0;
    in_bus.position = '0;
    in_bus.value    = '0;
    out_bus.ready   = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list and rejected requests
    send_beat(OP_CLEAR, 8'd0, 32'd0);
    send_beat(OP_DELETE, 8'd1, 32'd0);
    send_beat(OP_GET, 8'd1, 32'd0);
    send_beat(OP_LOCATE, 8'd0, 32'd0);
    send_beat(OP_INSERT, 8'd0, 32'd5);
    send_beat(OP_INSERT, 8'd2, 32'd5);
    // build [-1, 0, min, max]
    send_beat(OP_INSERT, 8'd1, 32'h8000_0000);
    send_beat(OP_INSERT, 8'd2, 32'h7fff_ffff);
    send_beat(OP_INSERT, 8'd1, 32'hffff_ffff);
    send_beat(OP_INSERT, 8'd2, 32'h0);
    send_beat(OP_INSERT, 8'hff, 32'd1);
    send_beat(OP_GET, 8'd0, 32'd0);
    send_beat(OP_GET, 8'd4, 32'd0);
    send_beat(OP_GET, 8'd5, 32'd0);
    send_beat(OP_LOCATE, 8'd0, 32'h7fff_ffff);
    // duplicate at the tail, locate must report the first one
    send_beat(OP_INSERT, 8'd5, 32'hffff_ffff);
    send_beat(OP_LOCATE, 8'd0, 32'hffff_ffff);
    send_beat(OP_LOCATE, 8'd0, 32'd12345);
    send_beat(OP_DELETE, 8'hff, 32'd0);
    send_beat(OP_DELETE, 8'd1, 32'd0);
    send_beat(OP_DELETE, 8'd4, 32'd0);
    send_beat(OP_DELETE, 8'd2, 32'd0);
    send_beat(3'(OP_CLEAR + 1), 8'($urandom), $urandom);
    send_beat(3'(OP_CLEAR + 2), 8'($urandom), $urandom);
    send_beat(OP_LAST, 8'($urandom), $urandom);
    send_beat(OP_CLEAR, 8'($urandom), $urandom);
    send_beat(OP_GET, 8'd1, 32'd0);

    issued = 0;
    seg    = 0;
    while (issued < RANDOM_ITEMS) begin
      case (seg)
        1, 6:    m = MODE_FILL;
        2:       m = MODE_MIX;
        7:       m = MODE_SHRINK;
        default: m = mix_mode_t'($urandom_range(MODE_SHRINK, MODE_GROW));
      endcase
      idle_on = (seg != 5 && seg != 6);
      if (seg == 3) hold_request = 1'b1;
      run_segment(m);
      if (seg == 4) wait_drained();
      seg++;
    end

    idle_on = 1'b1;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
